### hdl/gsip_pkg.sv
// shared types and constants for the gshare and indirect branch predictor
package gsip_pkg;

   localparam int CNT_IDX_W = 6;
   localparam int TGT_IDX_W = 4;
   localparam int HIST_W    = (CNT_IDX_W > TGT_IDX_W) ? CNT_IDX_W : TGT_IDX_W;
   localparam int CNT_DEPTH = 1 << CNT_IDX_W;
   localparam int TGT_DEPTH = 1 << TGT_IDX_W;
   localparam int ADDR_W    = 32;

   typedef logic signed [1:0]     cnt_type;
   typedef logic [CNT_IDX_W-1:0]  cnt_idx_type;
   typedef logic [TGT_IDX_W-1:0]  tgt_idx_type;
   typedef logic [HIST_W-1:0]     hist_type;

   localparam cnt_type CNT_MAX   = 2'sb01;
   localparam cnt_type CNT_MIN   = 2'sb10;
   localparam cnt_type CNT_RESET = 2'sb00;

   // operation codes
   localparam logic OP_FETCH  = 1'b0;
   localparam logic OP_RETIRE = 1'b1;

   // predictor modes
   localparam logic MODE_GSHARE   = 1'b0;
   localparam logic MODE_INDIRECT = 1'b1;

   typedef struct packed {
      logic        en;
      cnt_idx_type idx;
   } cnt_rd_type;

   typedef struct packed {
      logic        en;
      cnt_idx_type idx;
      cnt_type     value;
   } cnt_wr_type;

endpackage

### hdl/gshare_and_indirect_branch_predictor_unit.sv
// top level of the gshare and indirect branch predictor
//
// usage
//  - req channel: one branch event per item, either a fetch (asks for a
//    prediction) or a retire (trains the tables), with valid/ready handshake
//  - rsp channel: exactly one result item per request item, in order
//  - csr port: single write-only register, predictor mode (0 gshare,
//    1 indirect); any write clears both tables and both histories and must
//    only happen while the block is idle
//  - result path: an accepted request passes the table read register, then
//    the result register, before its result is offered on the rsp channel
//  - throughput: one item per cycle while rsp_ready stays high; the counter
//    table is read at most once and written at most once per cycle, the read
//    of an entry written at the same edge is served from a forwarding register
//  - reset: mode returns to gshare, histories clear, valid bits of both
//    tables drop so every entry reads as zero (weakly taken / target zero)
//  - stall: while rsp_ready is low the result register holds, the table
//    stage holds behind it and req_ready drops once both are full
module gshare_and_indirect_branch_predictor_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_operation,
   input  logic [gsip_pkg::ADDR_W-1:0] req_pc,
   input  logic                        req_is_conditional,
   input  logic                        req_is_indirect,
   input  logic                        req_is_branch,
   input  logic                        req_taken,
   input  logic [gsip_pkg::ADDR_W-1:0] req_actual_target,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_prediction_valid,
   output logic                        rsp_predict_taken,
   output logic [gsip_pkg::ADDR_W-1:0] rsp_predict_target,
   input  logic                        csr_write_enable,
   input  logic                        csr_write_data
);
   import gsip_pkg::*;

   // history shift: outcome for a conditional, 1 for any other branch
   function automatic hist_type hist_shift(hist_type h, logic cond, logic br, logic tk);
      hist_type res;
      priority if (cond) begin
         res = {h[HIST_W-2:0], tk};
      end else if (br) begin
         res = {h[HIST_W-2:0], 1'b1};
      end else begin
         res = h;
      end
      return res;
   endfunction

   // mode register and histories
   logic        mode_ff;
   hist_type    fetch_hist_ff, fetch_hist_in;
   hist_type    retire_hist_ff, retire_hist_in;

   // table stage
   logic        s1_vld_ff, s1_vld_in;
   logic        s1_op_ff;
   logic        s1_use_cnt_ff;
   logic        s1_use_tgt_ff;
   logic        s1_taken_ff;
   cnt_idx_type s1_cnt_idx_ff;
   tgt_idx_type s1_tgt_idx_ff;
   logic [ADDR_W-1:0] s1_target_ff;

   // result register
   logic        rsp_vld_ff, rsp_vld_in;
   logic        rsp_pv_ff;
   logic        rsp_pt_ff;
   logic [ADDR_W-1:0] rsp_tgt_ff;

   // target table, small enough for flops with valid bits
   logic [ADDR_W-1:0]    tgt_mem_ff [TGT_DEPTH];
   logic [TGT_DEPTH-1:0] tgt_vld_ff, tgt_vld_in;

   logic        req_fire;
   logic        s1_adv;
   hist_type    hist_sel;
   logic        use_cnt;
   logic        use_tgt;
   cnt_idx_type cnt_idx;
   tgt_idx_type tgt_idx;
   cnt_rd_type  cnt_rd;
   cnt_wr_type  cnt_wr;
   cnt_type     cnt_cur;
   cnt_type     cnt_next;
   logic        tgt_wr_en;
   logic [ADDR_W-1:0] tgt_cur;
   logic        res_pv;
   logic        res_pt;
   logic [ADDR_W-1:0] res_tgt;

   // handshake: table stage moves on when the result register is free
   assign s1_adv    = s1_vld_ff & (~rsp_vld_ff | rsp_ready);
   assign req_ready = ~s1_vld_ff | s1_adv;
   assign req_fire  = req_valid & req_ready;

   // index hash from the history of the requesting side
   assign hist_sel = (req_operation == OP_RETIRE) ? retire_hist_ff : fetch_hist_ff;
   assign use_cnt  = (mode_ff == MODE_GSHARE) & req_is_conditional;
   assign use_tgt  = (mode_ff == MODE_INDIRECT) & req_is_indirect;
   assign cnt_idx  = hist_sel[CNT_IDX_W-1:0] ^ req_pc[CNT_IDX_W-1:0];
   assign tgt_idx  = hist_sel[TGT_IDX_W-1:0] ^ req_pc[TGT_IDX_W-1:0];

   always_comb begin
      fetch_hist_in  = fetch_hist_ff;
      retire_hist_in = retire_hist_ff;
      if (req_fire) begin
         unique case (req_operation)
            OP_FETCH: begin
               fetch_hist_in = hist_shift(fetch_hist_ff, req_is_conditional,
                                          req_is_branch, req_taken);
            end
            OP_RETIRE: begin
               retire_hist_in = hist_shift(retire_hist_ff, req_is_conditional,
                                           req_is_branch, req_taken);
            end
            default: begin
               fetch_hist_in = fetch_hist_ff;
            end
         endcase
      end
      if (csr_write_enable) begin
         fetch_hist_in  = '0;
         retire_hist_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_GSHARE;
         fetch_hist_ff  <= '0;
         retire_hist_ff <= '0;
      end else begin
         if (csr_write_enable) begin
            mode_ff <= csr_write_data;
         end
         fetch_hist_ff  <= fetch_hist_in;
         retire_hist_ff <= retire_hist_in;
      end
   end

   // counter table read issued at accept
   assign cnt_rd.en  = req_fire;
   assign cnt_rd.idx = cnt_idx;

   gsip_counter_bank u_counter_bank (
      .clock    (clock),
      .reset    (reset),
      .clear    (csr_write_enable),
      .rd       (cnt_rd),
      .wr       (cnt_wr),
      .rd_value (cnt_cur)
   );

   assign s1_vld_in = req_fire | (s1_vld_ff & ~s1_adv);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_op_ff      <= req_operation;
         s1_use_cnt_ff <= use_cnt;
         s1_use_tgt_ff <= use_tgt;
         s1_taken_ff   <= req_taken;
         s1_cnt_idx_ff <= cnt_idx;
         s1_tgt_idx_ff <= tgt_idx;
         s1_target_ff  <= req_actual_target;
      end
   end

   // saturating counter training
   always_comb begin
      if (s1_taken_ff) begin
         cnt_next = (cnt_cur == CNT_MAX) ? cnt_cur : cnt_type'(cnt_cur + 2'sd1);
      end else begin
         cnt_next = (cnt_cur == CNT_MIN) ? cnt_cur : cnt_type'(cnt_cur - 2'sd1);
      end
   end

   assign cnt_wr.en    = s1_adv & (s1_op_ff == OP_RETIRE) & s1_use_cnt_ff;
   assign cnt_wr.idx   = s1_cnt_idx_ff;
   assign cnt_wr.value = cnt_next;

   // target table
   assign tgt_wr_en = s1_adv & (s1_op_ff == OP_RETIRE) & s1_use_tgt_ff;
   assign tgt_cur   = tgt_vld_ff[s1_tgt_idx_ff] ? tgt_mem_ff[s1_tgt_idx_ff] : '0;

   always_ff @(posedge clock) begin
      if (tgt_wr_en) begin
         tgt_mem_ff[s1_tgt_idx_ff] <= s1_target_ff;
      end
   end

   always_comb begin
      tgt_vld_in = tgt_vld_ff;
      if (tgt_wr_en) begin
         tgt_vld_in[s1_tgt_idx_ff] = 1'b1;
      end
      if (csr_write_enable) begin
         tgt_vld_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tgt_vld_ff <= '0;
      end else begin
         tgt_vld_ff <= tgt_vld_in;
      end
   end

   // fetch result; retire items return an all-zero result
   assign res_pv  = (s1_op_ff == OP_FETCH) & (s1_use_cnt_ff | s1_use_tgt_ff);
   assign res_pt  = (s1_op_ff == OP_FETCH) & s1_use_cnt_ff & ~cnt_cur[1];
   assign res_tgt = ((s1_op_ff == OP_FETCH) & s1_use_tgt_ff) ? tgt_cur : '0;

   assign rsp_vld_in = s1_adv | (rsp_vld_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_pv_ff  <= res_pv;
         rsp_pt_ff  <= res_pt;
         rsp_tgt_ff <= res_tgt;
      end
   end

   assign rsp_valid            = rsp_vld_ff;
   assign rsp_prediction_valid = rsp_pv_ff;
   assign rsp_predict_taken    = rsp_pt_ff;
   assign rsp_predict_target   = rsp_tgt_ff;

`ifndef SYNTHESIS
   a_stage_feeds_result : assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> rsp_vld_ff)
      else $error("table stage moved on but no result appeared");

   a_taken_needs_prediction : assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_pt_ff) |-> rsp_pv_ff)
      else $error("taken prediction without a valid prediction");

   a_target_needs_prediction : assert property (@(posedge clock) disable iff (reset)
      (s1_adv && res_tgt != '0) |-> (res_pv && !res_pt))
      else $error("target given outside an indirect fetch");

   a_csr_clears_targets : assert property (@(posedge clock) disable iff (reset)
      csr_write_enable |=> (tgt_vld_ff == '0 && fetch_hist_ff == '0 && retire_hist_ff == '0))
      else $error("mode write left predictor state behind");
`endif

endmodule

### hdl/gsip_counter_bank.sv
// counter table memory with per-entry valid bits and write forwarding
module gsip_counter_bank (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 clear,
   input  gsip_pkg::cnt_rd_type rd,
   input  gsip_pkg::cnt_wr_type wr,
   output gsip_pkg::cnt_type    rd_value
);
   import gsip_pkg::*;

   cnt_type               cnt_mem_ff [CNT_DEPTH];
   cnt_type               mem_rd_ff;
   cnt_idx_type           rd_idx_ff;
   logic [CNT_DEPTH-1:0]  cnt_vld_ff;
   logic [CNT_DEPTH-1:0]  cnt_vld_in;
   logic                  fwd_vld_ff;
   logic                  fwd_vld_in;
   cnt_idx_type           fwd_idx_ff;
   cnt_type               fwd_val_ff;

   // memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         cnt_mem_ff[wr.idx] <= wr.value;
      end
      if (rd.en) begin
         mem_rd_ff <= cnt_mem_ff[rd.idx];
         rd_idx_ff <= rd.idx;
      end
   end

   always_comb begin
      cnt_vld_in = cnt_vld_ff;
      if (wr.en) begin
         cnt_vld_in[wr.idx] = 1'b1;
      end
      if (clear) begin
         cnt_vld_in = '0;
      end
   end

   assign fwd_vld_in = clear ? 1'b0 : (wr.en | fwd_vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_vld_ff <= '0;
         fwd_vld_ff <= 1'b0;
      end else begin
         cnt_vld_ff <= cnt_vld_in;
         fwd_vld_ff <= fwd_vld_in;
      end
   end

   // last write is kept so a read issued at the same edge sees it
   always_ff @(posedge clock) begin
      if (wr.en) begin
         fwd_idx_ff <= wr.idx;
         fwd_val_ff <= wr.value;
      end
   end

   always_comb begin
      priority if (fwd_vld_ff && fwd_idx_ff == rd_idx_ff) begin
         rd_value = fwd_val_ff;
      end else if (cnt_vld_ff[rd_idx_ff]) begin
         rd_value = mem_rd_ff;
      end else begin
         rd_value = CNT_RESET;
      end
   end

`ifndef SYNTHESIS
   a_clear_drops_valid : assert property (@(posedge clock) disable iff (reset)
      clear |=> (cnt_vld_ff == '0 && !fwd_vld_ff))
      else $error("counter valid bits survive a clear");

   a_write_sets_valid : assert property (@(posedge clock) disable iff (reset)
      (wr.en && !clear) |=> (cnt_vld_ff[$past(wr.idx)] && fwd_vld_ff))
      else $error("counter write did not mark its entry valid");
`endif

endmodule
